[hw/rtl/stes_pkg.sv]
// Shared constants for the sorted key table with exponential search.
// Field widths, the default table depth and the action codes.
// No dependencies.
package stes_pkg;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int POS_W   = 10;

  // Default number of table entries
  localparam int STES_TABLE_DEPTH = 1024;

  // Action codes carried by an input word
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

endpackage

[hw/rtl/stes_keymem.sv]
// Key table storage: one write port, one registered read port.
// Depends on stes_pkg for the key width.
module stes_keymem import stes_pkg::*; #(
  parameter int TABLE_DEPTH = STES_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic signed [KEY_W-1:0]        wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic signed [KEY_W-1:0]        rd_data
);

  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

  // Store a key
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Fetch a key, hold the last one otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/sorted_table_exponential_search.sv]
// Sorted key table with exponential search: top level with the search sequencer.
// Depends on stes_pkg and stes_keymem.
//
// Usage:
//   cfg_we/cfg_wdata set entry_count, the number of valid sorted entries;
//   write it only while the block is idle. Counts above TABLE_DEPTH saturate.
//   Input words (in_valid/in_stall) carry action, entry_index and key_value.
//   A write word stores key_value at entry_index and gives no output
//   word; an index at or beyond TABLE_DEPTH is dropped.
//   A search word gives one output word (found, position) on out_valid/out_stall.
// Search sequence:
//   A search reads one entry at a time through the key memory's single read
//   port and one shared comparator: entry 0, up to log2(TABLE_DEPTH) doubling
//   probes, a setup step, up to log2(TABLE_DEPTH) binary probes, then the
//   result is posted. An empty table goes straight to posting a miss; the
//   next word can be taken once the result is posted.
//   in_stall stays high from acceptance of a search until its result is posted.
// Reset: rst clears entry_count, the sequencer and out_valid; table contents
//   are undefined until written.
// Stall: the result register holds while out_stall is high; a new search may
//   be accepted meanwhile but its result waits until the register is taken.
module sorted_table_exponential_search import stes_pkg::*; #(
  parameter int TABLE_DEPTH = STES_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [IDX_W-1:0]        entry_index,
  input  logic signed [KEY_W-1:0] key_value,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    found,
  output logic [POS_W-1:0]        position
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = AW + 1;
  localparam int CMP_W = (CW > CNT_W) ? CW : CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P0    = 3'd1;
  localparam logic [2:0] S_EXP   = 3'd2;
  localparam logic [2:0] S_BINIT = 3'd3;
  localparam logic [2:0] S_BIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state, state_next;
  logic [CNT_W-1:0]        entry_count;
  logic signed [KEY_W-1:0] target, target_next;
  logic [CW-1:0]           n, n_next;
  logic [CW-1:0]           probe, probe_next;
  logic [CW-1:0]           lo, lo_next;
  logic [CW-1:0]           hi, hi_next;
  logic [CW-1:0]           mid, mid_next;
  logic                    hit, hit_next;
  logic [CW-1:0]           hitpos, hitpos_next;

  logic                    in_take;
  logic                    out_free;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CW-1:0]           n_sat;
  logic [CMP_W-1:0]        idx_ext;
  logic                    wr_en;
  logic                    rd_en;
  logic [CW-1:0]           rd_addr;
  logic signed [KEY_W-1:0] rd_data;
  logic                    key_eq, key_gt;
  logic [CW-1:0]           probe2, probe_exit, n_m1;
  logic [CW-1:0]           lo_b, hi_b;
  logic [CW:0]             bsum;
  logic [CW-1:0]           mid_c;
  logic [CMP_W-1:0]        pos_ext;

  // Entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // Saturate the count to the table depth
  assign cnt_ext = CMP_W'(entry_count);
  assign n_sat   = (cnt_ext > CMP_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext[CW-1:0];

  // Handshake and table writes
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx_ext  = CMP_W'(entry_index);
  assign wr_en    = in_take && (action == ACT_WRITE) && (idx_ext < CMP_W'(TABLE_DEPTH));

  stes_keymem #(.TABLE_DEPTH(TABLE_DEPTH)) u_keymem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (key_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Shared comparator on the fetched key
  assign key_eq = (rd_data == target);
  assign key_gt = (rd_data > target);

  // Doubling probe and its exit bound
  assign probe2     = {probe[CW-2:0], 1'b0};
  assign probe_exit = key_gt ? probe : probe2;
  assign n_m1       = n - CW'(1);

  // Narrow the binary range after a miss
  always_comb begin
    lo_b = lo;
    hi_b = hi;
    if (state == S_BIN) begin
      if (key_gt) begin
        hi_b = mid - CW'(1);
      end else begin
        lo_b = mid + CW'(1);
      end
    end
  end

  assign bsum  = {1'b0, lo_b} + {1'b0, hi_b};
  assign mid_c = bsum[CW:1];

  // Search sequencer
  always_comb begin
    state_next  = state;
    target_next = target;
    n_next      = n;
    probe_next  = probe;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    hit_next    = hit;
    hitpos_next = hitpos;
    rd_en       = 1'b0;
    rd_addr     = '0;
    case (state)
      S_IDLE: begin
        if (in_take && (action == ACT_SEARCH)) begin
          target_next = key_value;
          n_next      = n_sat;
          if (n_sat == '0) begin
            hit_next    = 1'b0;
            hitpos_next = '0;
            state_next  = S_DONE;
          end else begin
            rd_en      = 1'b1;
            state_next = S_P0;
          end
        end
      end
      S_P0: begin
        if (key_eq) begin
          hit_next    = 1'b1;
          hitpos_next = '0;
          state_next  = S_DONE;
        end else if (n > CW'(1)) begin
          probe_next = CW'(1);
          rd_en      = 1'b1;
          rd_addr    = CW'(1);
          state_next = S_EXP;
        end else begin
          lo_next    = '0;
          hi_next    = '0;
          state_next = S_BINIT;
        end
      end
      S_EXP: begin
        if (!key_gt && (probe2 < n)) begin
          probe_next = probe2;
          rd_en      = 1'b1;
          rd_addr    = probe2;
        end else begin
          lo_next    = probe_exit >> 1;
          hi_next    = (probe_exit < n_m1) ? probe_exit : n_m1;
          state_next = S_BINIT;
        end
      end
      S_BINIT: begin
        mid_next   = mid_c;
        rd_en      = 1'b1;
        rd_addr    = mid_c;
        state_next = S_BIN;
      end
      S_BIN: begin
        if (key_eq) begin
          hit_next    = 1'b1;
          hitpos_next = mid;
          state_next  = S_DONE;
        end else if ((key_gt && (mid == lo)) || (!key_gt && (mid == hi))) begin
          hit_next    = 1'b0;
          hitpos_next = '0;
          state_next  = S_DONE;
        end else begin
          lo_next    = lo_b;
          hi_next    = hi_b;
          mid_next   = mid_c;
          rd_en      = 1'b1;
          rd_addr    = mid_c;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the search context
  always_ff @(posedge clk) begin
    target <= target_next;
    n      <= n_next;
    probe  <= probe_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    hit    <= hit_next;
    hitpos <= hitpos_next;
  end

  // Result register: post a word when done, drop it once taken
  assign pos_ext = CMP_W'(hitpos);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      found    <= hit;
      position <= pos_ext[POS_W-1:0];
    end
  end

endmodule
